// ===== src/chbd_pkg.sv =====
package chbd_pkg;

    // Result kind codes
    typedef logic [2:0] kind_t;

    localparam kind_t K_FRAME    = 3'd0;
    localparam kind_t K_PAYLOAD  = 3'd1;
    localparam kind_t K_END      = 3'd2;
    localparam kind_t K_BOUNDARY = 3'd3;
    localparam kind_t K_OVERFLOW = 3'd4;
    localparam kind_t K_DISCARD  = 3'd5;

    typedef logic [7:0] byte_t;

    localparam byte_t CH_CR = 8'h0D;
    localparam byte_t CH_LF = 8'h0A;

    // Hex digit decode: bit 4 set when the byte is a hex digit, bits 3:0 its value
    function automatic logic [4:0] hex_digit(input byte_t c);
        logic [4:0] r;
        begin
            r = 5'd0;
            if (c >= 8'h30 && c <= 8'h39)
            begin
                r = {1'b1, 4'(c - 8'h30)};
            end
            else if (c >= 8'h61 && c <= 8'h66)
            begin
                r = {1'b1, 4'(c - 8'h57)};
            end
            else if (c >= 8'h41 && c <= 8'h46)
            begin
                r = {1'b1, 4'(c - 8'h37)};
            end
            return r;
        end
    endfunction

endpackage

// ===== src/chbd_in_stage.sv =====
module chbd_in_stage (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  chbd_pkg::byte_t data_byte,
    output logic           hold_valid,
    input  logic           hold_ready,
    output chbd_pkg::byte_t hold_byte
);
    import chbd_pkg::*;

    logic  valid_reg;
    byte_t byte_reg;

    // Take a new byte whenever the held one leaves or the stage is empty
    assign in_ready = !valid_reg || hold_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    // Load payload on every transfer
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            byte_reg <= data_byte;
        end
    end

    assign hold_valid = valid_reg;
    assign hold_byte  = byte_reg;

endmodule

// ===== src/chbd_decode.sv =====
module chbd_decode #(
    parameter int SIZE_BITS  = 32,
    parameter int LINE_LIMIT = 4096
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            byte_valid,
    output logic            byte_ready,
    input  chbd_pkg::byte_t byte_in,
    output logic            out_valid,
    input  logic            out_ready,
    output chbd_pkg::kind_t kind,
    output chbd_pkg::byte_t out_byte,
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic            cfg_data
);
    import chbd_pkg::*;

    localparam int LC_W = $clog2(LINE_LIMIT + 1);

    localparam logic [2:0] PH_HEX  = 3'd0;
    localparam logic [2:0] PH_EXT  = 3'd1;
    localparam logic [2:0] PH_DATA = 3'd2;
    localparam logic [2:0] PH_CRLF = 3'd3;
    localparam logic [2:0] PH_DONE = 3'd4;

    logic                 mode_reg;
    logic [2:0]           phase_reg, phase_next;
    logic [SIZE_BITS-1:0] remaining_reg, remaining_next;
    logic [LC_W-1:0]      line_count_reg, line_count_next;
    logic                 saw_cr_reg, saw_cr_next;

    logic  res_valid_reg;
    kind_t kind_reg, kind_next;
    byte_t ob_reg, ob_next;

    logic                 fire;
    logic [4:0]           hd;
    logic [SIZE_BITS-1:0] rem_dec;

    // Result stage is free when empty or being drained
    assign byte_ready = !res_valid_reg || out_ready;
    assign fire       = byte_valid && byte_ready;
    assign cfg_ready  = 1'b1;

    assign hd      = hex_digit(byte_in);
    assign rem_dec = remaining_reg - SIZE_BITS'(1);

    // Next state and result for the byte at the head of the input stage
    always_comb
    begin
        phase_next      = phase_reg;
        remaining_next  = remaining_reg;
        line_count_next = line_count_reg;
        saw_cr_next     = saw_cr_reg;
        kind_next       = K_FRAME;
        ob_next         = 8'd0;

        if (!mode_reg)
        begin
            kind_next = K_PAYLOAD;
            ob_next   = byte_in;
        end
        else
        begin
            unique case (phase_reg)
                PH_HEX, PH_EXT:
                begin
                    if (phase_reg == PH_EXT && saw_cr_reg && byte_in == CH_LF)
                    begin
                        // Close the size line
                        saw_cr_next     = 1'b0;
                        line_count_next = '0;
                        if (remaining_reg == '0)
                        begin
                            phase_next = PH_DONE;
                            kind_next  = K_END;
                        end
                        else
                        begin
                            phase_next = PH_DATA;
                        end
                    end
                    else if (line_count_reg >= LC_W'(LINE_LIMIT))
                    begin
                        phase_next = PH_DONE;
                        kind_next  = K_OVERFLOW;
                    end
                    else
                    begin
                        line_count_next = line_count_reg + LC_W'(1);
                        if (phase_reg == PH_HEX && hd[4])
                        begin
                            // Accumulate a digit, saturating at the maximum size
                            if (remaining_reg[SIZE_BITS-1 -: 4] != 4'd0)
                            begin
                                remaining_next = '1;
                            end
                            else
                            begin
                                remaining_next = {remaining_reg[SIZE_BITS-5:0], hd[3:0]};
                            end
                        end
                        else
                        begin
                            phase_next  = PH_EXT;
                            saw_cr_next = (byte_in == CH_CR);
                        end
                    end
                end
                PH_DATA:
                begin
                    kind_next = K_PAYLOAD;
                    ob_next   = byte_in;
                    if (remaining_reg == '0 || rem_dec == '0)
                    begin
                        remaining_next = '0;
                        phase_next     = PH_CRLF;
                        saw_cr_next    = 1'b0;
                    end
                    else
                    begin
                        remaining_next = rem_dec;
                    end
                end
                PH_CRLF:
                begin
                    if (!saw_cr_reg)
                    begin
                        if (byte_in == CH_CR)
                        begin
                            saw_cr_next = 1'b1;
                        end
                        else
                        begin
                            kind_next  = K_BOUNDARY;
                            phase_next = PH_DONE;
                        end
                    end
                    else if (byte_in == CH_LF)
                    begin
                        saw_cr_next     = 1'b0;
                        remaining_next  = '0;
                        line_count_next = '0;
                        phase_next      = PH_HEX;
                    end
                    else
                    begin
                        kind_next  = K_BOUNDARY;
                        phase_next = PH_DONE;
                    end
                end
                default:
                begin
                    kind_next  = K_DISCARD;
                    phase_next = PH_DONE;
                end
            endcase
        end
    end

    // Decoder state and mode register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= 1'b1;
            phase_reg      <= PH_HEX;
            remaining_reg  <= '0;
            line_count_reg <= '0;
            saw_cr_reg     <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                mode_reg <= cfg_data;
            end
            if (fire)
            begin
                phase_reg      <= phase_next;
                remaining_reg  <= remaining_next;
                line_count_reg <= line_count_next;
                saw_cr_reg     <= saw_cr_next;
            end
            if (byte_ready)
            begin
                res_valid_reg <= byte_valid;
            end
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            kind_reg <= kind_next;
            ob_reg   <= ob_next;
        end
    end

    assign out_valid = res_valid_reg;
    assign kind      = kind_reg;
    assign out_byte  = ob_reg;

    // Finished phase is terminal until reset
    assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_DONE |=> phase_reg == PH_DONE)
        else $error("left finished phase");

    // Chunk data phase always has bytes left
    assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_DATA |-> remaining_reg != '0)
        else $error("data phase with zero remaining");

    // Size line counter never passes the limit
    assert property (@(posedge clk) disable iff (!rst_n)
        line_count_reg <= LC_W'(LINE_LIMIT))
        else $error("line counter past limit");

    // Non-payload results carry a zero byte
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind != K_PAYLOAD |-> out_byte == 8'd0)
        else $error("stray byte on non-payload result");

endmodule

// ===== src/http_chunked_body_decoder.sv =====
// HTTP/1.1 chunked body decoder.
// Feed response body bytes, starting right after the header, on the
// in_valid/in_ready/data_byte channel. Each byte yields exactly one result
// on out_valid/out_ready with a kind code and out_byte (payload when kind is
// payload, otherwise zero): framing, payload, end of body, boundary error,
// line overflow or discarded.
// cfg_valid/cfg_ready/cfg_data writes the chunked mode bit (1 decodes, 0
// passes bytes through); cfg_ready is always high. Write it only when idle.
// A byte transferred on the input is first held in the input register, then
// decoded into the result register, from which it leaves.
// Throughput: one byte per cycle while the receiver does not stall, set by the
// combinational decode between the input register and the result register.
// While the receiver stalls, the result register holds its result and the
// input register holds one more byte; in_ready then drops.
// Reset enables chunked mode, starts at the first size line and empties
// both registers. After end of body or any error every byte is discarded in
// chunked mode until the next reset.
module http_chunked_body_decoder #(
    parameter int SIZE_BITS  = 32,
    parameter int LINE_LIMIT = 4096
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  chbd_pkg::byte_t data_byte,
    output logic            out_valid,
    input  logic            out_ready,
    output chbd_pkg::kind_t kind,
    output chbd_pkg::byte_t out_byte,
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic            cfg_data
);
    import chbd_pkg::*;

    logic  hold_valid;
    logic  hold_ready;
    byte_t hold_byte;

    // Input register
    chbd_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .data_byte  (data_byte),
        .hold_valid (hold_valid),
        .hold_ready (hold_ready),
        .hold_byte  (hold_byte)
    );

    // Decode and result register
    chbd_decode #(
        .SIZE_BITS  (SIZE_BITS),
        .LINE_LIMIT (LINE_LIMIT)
    ) u_decode (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (hold_valid),
        .byte_ready (hold_ready),
        .byte_in    (hold_byte),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .kind       (kind),
        .out_byte   (out_byte),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data)
    );

endmodule
